>>> sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared codes and control structs of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  // response status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // capacity register
  localparam int          CAP_BITS  = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  // search token that walks the cell chain
  typedef struct packed {
    logic active;
    logic hit;
    logic free_found;
  } scan_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic find_hit;
    logic insert;
    logic evict;
  } upd_t;

endpackage

>>> sv/lkv_req_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if
// request channel: insert or find with key and value
// ----------------------------------------------------------------------------
interface lkv_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

>>> sv/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// lkv_rsp_if
// response channel: status, found value and eviction flag
// ----------------------------------------------------------------------------
interface lkv_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic                  evicted;

  modport source (output valid, status, found_value, evicted, input ready);
  modport sink   (input valid, status, found_value, evicted, output ready);
endinterface

>>> sv/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// one cache slot: key, value, valid and recency rank, plus one link of the
// search chain
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int RANK_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] req_value,
  input  lkv_pkg::scan_t        scan_in,
  input  logic [VALUE_BITS-1:0] scan_value_in,
  input  logic [RANK_W-1:0]     scan_rank_in,
  output lkv_pkg::scan_t        scan_out,
  output logic [VALUE_BITS-1:0] scan_value_out,
  output logic [RANK_W-1:0]     scan_rank_out,
  input  lkv_pkg::upd_t         upd,
  input  logic [RANK_W-1:0]     hit_rank,
  input  logic [RANK_W-1:0]     lru_rank,
  output logic                  valid,
  output logic                  hit,
  output logic                  claim
);

  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [RANK_W-1:0]     rank;
  logic                  first_free;
  logic                  hit_here;

  assign hit_here = valid && (key == req_key);

  // this slot takes the new entry: the least recent one, or the first free one
  assign claim = upd.insert &&
                 (upd.evict ? (valid && (rank == lru_rank)) : first_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      rank       <= '0;
      hit        <= 1'b0;
      first_free <= 1'b0;
      scan_out   <= '0;
    end else begin
      scan_out.active     <= scan_in.active;
      scan_out.hit        <= scan_in.hit | (scan_in.active & hit_here);
      scan_out.free_found <= scan_in.free_found | (scan_in.active & ~valid);
      if (scan_in.active) begin
        hit        <= hit_here;
        first_free <= !valid && !scan_in.free_found;
      end
      if (claim) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (upd.find_hit) begin
        if (hit) begin
          rank <= '0;
        end else if (valid && (rank < hit_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end else if (upd.insert && valid) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  // payload of the chain and of the slot
  always_ff @(posedge clk) begin
    scan_value_out <= scan_value_in | (hit_here ? value : '0);
    scan_rank_out  <= scan_rank_in | (hit_here ? rank : '0);
    if (claim) begin
      key   <= req_key;
      value <= req_value;
    end
  end

endmodule

>>> sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// The store is a chain of MAX_ENTRIES identical slot cells. An accepted
// request sends a search token down the chain, one cell per cycle; each cell
// compares its key against the request and folds its hit, value, rank and
// free state into the token. When the token leaves the last cell the outcome
// is known, and the update state broadcasts the command: a find hit moves the
// entry to rank 0, an insert writes the least recent slot (at capacity) or the
// lowest free slot; an insert ages all other valid entries, a find hit only
// those more recent than the hit entry. A new request is accepted only once
// the previous one has passed its update. A response waiting on rsp does not
// stop the next request from being accepted; only its update cycle waits for
// the output register.
// Capacity is written through cfg_we / cfg_wdata; the user must write it
// only while idle, which the block does not enforce. 0 acts as 1, values
// above MAX_ENTRIES act as MAX_ENTRIES, and lowering it below the current
// count never drops entries.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  lkv_req_if.sink                       req,
  lkv_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_wdata
);

  localparam int RANK_W  = $clog2(MAX_ENTRIES);
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = (COUNT_W > lkv_pkg::CAP_BITS) ? COUNT_W : lkv_pkg::CAP_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]                   state;
  logic [lkv_pkg::CAP_BITS-1:0] capacity;
  logic [COUNT_W-1:0]           count;

  // request held for the whole transaction
  logic                  req_type_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;

  // search outcome taken from the end of the chain
  logic                  hit_r;
  logic [VALUE_BITS-1:0] found_r;
  logic [RANK_W-1:0]     hit_rank_r;

  // output register
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [VALUE_BITS-1:0] out_found;
  logic                  out_evicted;

  lkv_pkg::scan_t        inject;
  lkv_pkg::scan_t        chain_ctl   [0:MAX_ENTRIES];
  logic [VALUE_BITS-1:0] chain_value [0:MAX_ENTRIES];
  logic [RANK_W-1:0]     chain_rank  [0:MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] claim_vec;

  lkv_pkg::upd_t    upd;
  logic             accept;
  logic             upd_en;
  logic             is_find;
  logic             find_hit;
  logic             do_insert;
  logic             do_evict;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [RANK_W-1:0] lru_rank;
  logic [1:0]       status_next;

  // handshakes
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign upd_en    = (state == ST_UPDATE) && (!out_valid || rsp.ready);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_found;
  assign rsp.evicted     = out_evicted;

  // effective capacity, clamped to 1..MAX_ENTRIES
  assign cap_ext   = CMP_W'(capacity);
  assign count_ext = CMP_W'(count);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // decision once the search is done
  assign is_find   = (req_type_r == lkv_pkg::REQ_FIND);
  assign find_hit  = is_find && hit_r;
  assign do_insert = !is_find && !hit_r;
  assign do_evict  = do_insert && (count_ext >= eff_cap) && (count != '0);
  assign lru_rank  = RANK_W'(count - COUNT_W'(1));

  always_comb begin
    if (is_find) begin
      status_next = hit_r ? lkv_pkg::STATUS_OK : lkv_pkg::STATUS_MISS;
    end else begin
      status_next = hit_r ? lkv_pkg::STATUS_DUP : lkv_pkg::STATUS_OK;
    end
  end

  always_comb begin
    upd = '0;
    if (upd_en) begin
      upd.find_hit = find_hit;
      upd.insert   = do_insert;
      upd.evict    = do_evict;
    end
  end

  // head of the chain: a fresh token with nothing found yet
  assign chain_ctl[0]   = inject;
  assign chain_value[0] = '0;
  assign chain_rank[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_W     (RANK_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .req_key        (req_key_r),
      .req_value      (req_value_r),
      .scan_in        (chain_ctl[i]),
      .scan_value_in  (chain_value[i]),
      .scan_rank_in   (chain_rank[i]),
      .scan_out       (chain_ctl[i+1]),
      .scan_value_out (chain_value[i+1]),
      .scan_rank_out  (chain_rank[i+1]),
      .upd            (upd),
      .hit_rank       (hit_rank_r),
      .lru_rank       (lru_rank),
      .valid          (valid_vec[i]),
      .hit            (hit_vec[i]),
      .claim          (claim_vec[i])
    );
  end

  // sequencer, count, capacity and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= lkv_pkg::CAP_RESET;
      count     <= '0;
      inject    <= '0;
      out_valid <= 1'b0;
    end else begin
      inject.active <= accept;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (upd_en) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (upd_en && do_insert && !do_evict) begin
        count <= count + COUNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // token has left the last cell
          if (chain_ctl[MAX_ENTRIES].active) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_en) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= req.req_type;
      req_key_r   <= req.key;
      req_value_r <= req.value;
    end
    if ((state == ST_SCAN) && chain_ctl[MAX_ENTRIES].active) begin
      hit_r      <= chain_ctl[MAX_ENTRIES].hit;
      found_r    <= chain_value[MAX_ENTRIES];
      hit_rank_r <= chain_rank[MAX_ENTRIES];
    end
    if (upd_en) begin
      out_status  <= status_next;
      out_found   <= find_hit ? found_r : '0;
      out_evicted <= do_evict;
    end
  end

  // count never runs past the slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count above slot count");

  // count tracks the number of valid slots
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count does not match valid slots");

  // an insert writes exactly one slot
  a_one_claim: assert property (@(posedge clk) disable iff (rst)
    (upd_en && do_insert) |-> $onehot(claim_vec))
    else $error("insert target is not a single slot");

  // keys are unique, and the chain result agrees with the cells
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ($onehot0(hit_vec) && (hit_r == (|hit_vec))))
    else $error("search result inconsistent with cell hits");

  // the update only follows a finished search
  a_update_after_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && chain_ctl[MAX_ENTRIES].active) |=> (state == ST_UPDATE))
    else $error("update did not follow the search");

endmodule

>>> sim/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// self-checking bench: random and directed inserts and finds, each response
// checked against a cycle-free software copy of the lru store
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;

  localparam int MAX_ENTRIES   = 16;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  // settle time after draining, scaled with the chain length
  localparam int SETTLE_CYCLES = 2 * (MAX_ENTRIES + 3);
  // cycles with no transaction on either channel before the run is called hung
  localparam int HANG_LIMIT    = 2000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic                  evicted;
  } cache_rsp_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [lkv_pkg::CAP_BITS-1:0] cfg_wdata;

  lkv_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
  lkv_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

  lru_key_value_cache #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // requests waiting to be sent, and responses the store should give back
  cache_req_t request_q[$];
  cache_rsp_t expected_rsp_q[$];
  cache_req_t sent_req;
  int         mismatch_count;

  // idle control shared by both sides: 0 means no idling, else 1 in N odds
  int idle_odds;
  bit calm;
  int send_gap;
  int recv_stall;

  // software copy of the store
  logic [KEY_BITS-1:0]          slot_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]        slot_value [MAX_ENTRIES];
  bit                           slot_live  [MAX_ENTRIES];
  int                           slot_age   [MAX_ENTRIES];
  int                           live_count;
  logic [lkv_pkg::CAP_BITS-1:0] capacity_reg;

  logic [lkv_pkg::CAP_BITS-1:0] phase_cap  [NUM_PHASES];
  int                           phase_odds [NUM_PHASES];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // move slot s to the front; live slots younger than limit age by one
  function automatic void make_recent(int s, int limit);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (i != s && slot_live[i] && slot_age[i] < limit)
        slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // apply one accepted request to the copy and return the response it owes
  function automatic cache_rsp_t predict_response(cache_req_t r);
    cache_rsp_t o;
    int         hit;
    int         victim;
    int         room;
    o.status      = lkv_pkg::STATUS_OK;
    o.found_value = '0;
    o.evicted     = 1'b0;
    hit = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == r.key)
        hit = i;
    // zero acts as one, anything past the slot count acts as the slot count
    if (capacity_reg == 0)
      room = 1;
    else if (capacity_reg > MAX_ENTRIES)
      room = MAX_ENTRIES;
    else
      room = int'(capacity_reg);

    if (r.req_type == lkv_pkg::REQ_FIND) begin
      if (hit >= 0) begin
        o.found_value = slot_value[hit];
        make_recent(hit, slot_age[hit]);
      end else begin
        o.status = lkv_pkg::STATUS_MISS;
      end
    end else if (hit >= 0) begin
      // duplicate key: refused, recency untouched
      o.status = lkv_pkg::STATUS_DUP;
    end else begin
      victim = -1;
      if (live_count >= room && live_count > 0) begin
        // full: reuse the least recent slot, one eviction only
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot_live[i] && slot_age[i] == live_count - 1)
            victim = i;
        if (victim < 0)
          victim = 0;
        o.evicted = 1'b1;
        slot_live[victim] = 1'b0;
        live_count--;
      end else begin
        // lowest free slot
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
          if (!slot_live[i])
            victim = i;
        if (victim < 0)
          victim = 0;
      end
      slot_key[victim]   = r.key;
      slot_value[victim] = r.value;
      slot_live[victim]  = 1'b1;
      make_recent(victim, MAX_ENTRIES + 1);
      if (live_count < MAX_ENTRIES)
        live_count++;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  task automatic push_request(logic kind, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    cache_req_t r;
    r.req_type = kind;
    r.key      = k;
    r.value    = v;
    request_q.push_back(r);
  endtask

  // capacity write, only ever issued while the store is idle
  task automatic set_capacity(logic [lkv_pkg::CAP_BITS-1:0] cap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity_reg = cap;
  endtask

  // hold off until every request is sent and answered, then let the chain settle
  task automatic wait_drained();
    do
      @(negedge clk);
    while (request_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random traffic over a small key pool so hits, duplicates and evictions are common
  task automatic queue_random_traffic(int count);
    logic [KEY_BITS-1:0] pool[$];
    logic [KEY_BITS-1:0] k;
    int                  n;
    logic                kind;
    n = $urandom_range(3, 24);
    repeat (n) pool.push_back($urandom);
    repeat (count) begin
      kind = ($urandom_range(0, 99) < 45) ? lkv_pkg::REQ_INSERT : lkv_pkg::REQ_FIND;
      // a few keys from outside the pool keep misses and fresh inserts coming
      k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, n - 1)];
      push_request(kind, k, $urandom);
    end
  endtask

  // driver: one item on the bus at a time, predicted when its transaction happens
  always @(posedge clk) begin : driver
    bit fire;
    bit load;
    fire = req_ch.valid && req_ch.ready;
    load = 1'b0;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (fire)
        expected_rsp_q.push_back(predict_response(sent_req));
      if (!req_ch.valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() != 0) begin
          // rolls repeat every empty cycle, so bursts can chain into long gaps
          if (!calm && idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
            send_gap = $urandom_range(1, 9) - 1;
          else
            load = 1'b1;
        end
        if (load) begin
          sent_req = request_q.pop_front();
          req_ch.req_type <= sent_req.req_type;
          req_ch.key      <= sent_req.key;
          req_ch.value    <= sent_req.value;
        end
        req_ch.valid <= load;
      end
    end
  end

  // monitor: compare each response transaction against the oldest expectation
  always @(posedge clk) begin : monitor
    cache_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("response with nothing outstanding: status %0d value %h evicted %0d",
                     rsp_ch.status, rsp_ch.found_value, rsp_ch.evicted);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
          if (rsp_ch.found_value !== want.found_value)
            report_mismatch("found_value", want.found_value, rsp_ch.found_value);
          if (rsp_ch.evicted !== want.evicted)
            report_mismatch("evicted", 32'(want.evicted), 32'(rsp_ch.evicted));
        end
      end
      if (recv_stall > 0)
        recv_stall--;
      else if (!calm && idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
        recv_stall = $urandom_range(1, 9);
      rsp_ch.ready <= (recv_stall == 0);
    end
  end

  // hang detection: any transaction on either channel restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("lru_key_value_cache_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    // known values on every input from time zero
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = lkv_pkg::REQ_INSERT;
    req_ch.key      = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    calm            = 1'b0;
    idle_odds       = 0;
    mismatch_count  = 0;
    capacity_reg    = lkv_pkg::CAP_RESET;
    live_count      = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_live[i]  = 1'b0;
      slot_age[i]   = 0;
    end
    // caps: small stores first while the count is low, then lowered below the count
    phase_cap  = '{5'd3, 5'd6, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16, 5'd16};
    phase_odds = '{2, 0, 4, 2, 3, 0, 2, 0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero capacity behaves as a single entry
    idle_odds = 2;
    set_capacity(5'd0);
    push_request(lkv_pkg::REQ_FIND,   32'h0000_0000, 32'h0000_0000);  // empty store miss
    push_request(lkv_pkg::REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(lkv_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);  // evicts key zero
    push_request(lkv_pkg::REQ_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
    push_request(lkv_pkg::REQ_FIND,   32'hFFFF_FFFF, 32'h1234_5678);
    push_request(lkv_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);  // refused duplicate
    wait_drained();

    set_capacity(5'd1);
    push_request(lkv_pkg::REQ_INSERT, 32'h0000_0001, 32'hAAAA_5555);
    push_request(lkv_pkg::REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_cap[p]);
      idle_odds = phase_odds[p];
      calm      = (p == NUM_PHASES - 1);
      if (phase_cap[p] == 5'd31) begin
        // over-range capacity: fill past the slot count so eviction starts at the top
        for (int i = 0; i < 14; i++)
          push_request(lkv_pkg::REQ_INSERT, 32'h8000_0000 | i, ~i);
        push_request(lkv_pkg::REQ_FIND, 32'h8000_000D, 32'h0000_0000);
      end
      queue_random_traffic(PHASE_ITEMS);
      // sender holds here until every response is back
      wait_drained();
    end

    if (mismatch_count == 0 && expected_rsp_q.size() == 0)
      $display("lru_key_value_cache_test: PASS");
    else
      $display("lru_key_value_cache_test: FAIL");
    $finish;
  end

endmodule

>>> lru_key_value_cache.f
sv/lkv_pkg.sv
sv/lkv_req_if.sv
sv/lkv_rsp_if.sv
sv/lkv_cell.sv
sv/lru_key_value_cache.sv
sim/lru_key_value_cache_test.sv
